// File: hw/rtl/mandelbrot_escape_pixel_macros.svh
// Assertion helpers for the escape-time block
`ifndef MANDELBROT_ESCAPE_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define MEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define MEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/mep_pkg.sv
package mep_pkg;

    localparam int WORD_W      = 48;
    localparam int HALF_W      = 24;
    localparam int OPND_W      = HALF_W + 1;
    localparam int PP_W        = 2 * OPND_W;
    localparam int ACC_W       = 2 * WORD_W;
    localparam int LIMIT_W     = 13;
    localparam int PAL_W       = 8;
    localparam int IN_TDATA_W  = 2 * WORD_W;
    localparam int OUT_TDATA_W = 24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd192;

    localparam int PAL_STEP = 13;
    localparam int PAL_MOD  = 216;
    localparam int PAL_BASE = 16;

    localparam logic [1:0] SEL_CROSS = 2'd0;
    localparam logic [1:0] SEL_RR    = 2'd1;
    localparam logic [1:0] SEL_II    = 2'd2;

    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_HL = 2'd1;
    localparam logic [1:0] PH_LH = 2'd2;
    localparam logic [1:0] PH_HH = 2'd3;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] phase;
        logic [1:0] sel;
        logic       wr_prod;
        logic       upd;
        logic       out_load;
    } mep_cmd_t;

    typedef struct packed {
        logic escaped;
        logic at_limit;
    } mep_stat_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic hi_ones;
        logic hi_zero;
        hi_ones = &v[ACC_W-1:WORD_W-1];
        hi_zero = ~(|v[ACC_W-1:WORD_W-1]);
        if (hi_ones || hi_zero)
        begin
            return v[WORD_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            return WORD_MIN;
        end
        else
        begin
            return WORD_MAX;
        end
    endfunction

endpackage

// File: hw/rtl/mandelbrot_escape_pixel.sv
// Channel   Direction  Beat contents
// s_axis    in         point_real, point_imag (one point c)
// m_axis    out        palette_index, iteration_count (one result per point)
// cfg       in         iteration_limit (13 bits)
//
// One point is in flight at a time. Each iteration runs three 48x48 products
// through one 25x25 multiplier as four partial products, then drain and write
// states; the update follows the cross product, the escape check the third.
// The result register frees s_axis: a new point is taken while a result still waits.
// Reset (rst_n low, asynchronous) empties the block and sets the limit to 192.
`include "mandelbrot_escape_pixel_macros.svh"

module mandelbrot_escape_pixel
    import mep_pkg::*;
#(
    parameter int FRAC_BITS = 44,
    parameter int ITER_MAX  = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [47:0] point_real, [95:48] point_imag
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] palette_index, [20:8] iteration_count, [23:21] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LIMIT_W-1:0]     cfg_data
);

    mep_cmd_t  cmd;
    mep_stat_t stat;

    assign cfg_ready = 1'b1;

    mep_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    mep_dp #(
        .FRAC_BITS (FRAC_BITS),
        .ITER_MAX  (ITER_MAX)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .in_data  (s_axis_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_axis_tdata)
    );

    `MEP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `MEP_ASSERT_NOW(a_load_into_free_slot, clk, rst_n, cmd.out_load, !m_axis_tvalid || m_axis_tready)
    `MEP_ASSERT_NEXT(a_limit_gives_zero, clk, rst_n, cmd.out_load && stat.at_limit, m_axis_tdata[7:0] == 8'd0)
    `MEP_ASSERT_NEXT(a_escape_in_palette, clk, rst_n, cmd.out_load && !stat.at_limit, m_axis_tdata[7:0] >= 8'd16 && m_axis_tdata[7:0] <= 8'd231)

endmodule

// File: hw/rtl/mep_ctrl.sv
module mep_ctrl
    import mep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    output logic      m_axis_tvalid,
    input  logic      m_axis_tready,
    input  mep_stat_t stat,
    output mep_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        phase_next = phase_reg;
        cmd          = '0;
        cmd.sel      = sel_reg;
        cmd.phase    = phase_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.at_limit || stat.escaped)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sel_next   = SEL_CROSS;
                    phase_next = PH_LL;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                phase_next = phase_reg + 2'd1;
                if (phase_reg == PH_HH)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.wr_prod = 1'b1;
                phase_next  = PH_LL;
                if (sel_reg == SEL_CROSS)
                begin
                    state_next = ST_UPD;
                end
                else if (sel_reg == SEL_RR)
                begin
                    sel_next   = SEL_II;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                sel_next   = SEL_RR;
                phase_next = PH_LL;
                state_next = ST_MUL;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_CROSS;
            phase_reg     <= PH_LL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/mep_dp.sv
module mep_dp
    import mep_pkg::*;
#(
    parameter int FRAC_BITS = 44,
    parameter int ITER_MAX  = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [LIMIT_W-1:0]     cfg_data,
    input  logic [IN_TDATA_W-1:0]  in_data,
    input  mep_cmd_t               cmd,
    output mep_stat_t              stat,
    output logic [OUT_TDATA_W-1:0] out_data
);

    localparam int CNT_W = $clog2(ITER_MAX + 1);
    localparam int EXT_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int SUM_W = (FRAC_BITS + 3 > WORD_W + 1) ? FRAC_BITS + 3 : WORD_W + 1;
    localparam int ZS_W  = WORD_W + 2;

    logic [LIMIT_W-1:0]        limit_cfg_reg;
    logic [CNT_W-1:0]          limit_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [PAL_W-1:0]          pal_acc_reg;
    logic signed [WORD_W-1:0]  cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [WORD_W-1:0]  rr_reg, ii_reg, cross_reg;
    logic signed [PP_W-1:0]    pp_reg, pp_next;
    logic [1:0]                pp_phase_reg;
    logic                      pp_valid_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [PAL_W-1:0]          out_pal_reg;
    logic [LIMIT_W-1:0]        out_cnt_reg;

    logic [EXT_W-1:0]          lim_ext, lim_eff, cnt_ext;
    logic signed [WORD_W-1:0]  word_a, word_b;
    logic signed [OPND_W-1:0]  op_a, op_b;
    logic signed [ACC_W-1:0]   pp_ext, pp_shl, acc_base;
    logic signed [ACC_W-1:0]   prod_shx, prod_shs;
    logic signed [WORD_W-1:0]  prod_sat;
    logic signed [ZS_W-1:0]    zr_sum, zi_sum;
    logic [SUM_W-1:0]          mag_sum;
    logic [PAL_W:0]            pal_inc;
    logic [PAL_W-1:0]          pal_step;
    logic [PAL_W-1:0]          pal_out;

    assign lim_ext = EXT_W'(limit_cfg_reg);
    assign lim_eff = (lim_ext > EXT_W'(ITER_MAX)) ? EXT_W'(ITER_MAX) : lim_ext;
    assign cnt_ext = EXT_W'(count_reg);

    assign mag_sum = SUM_W'(rr_reg[WORD_W-2:0]) + SUM_W'(ii_reg[WORD_W-2:0]);
    assign stat.escaped  = mag_sum >= (SUM_W'(4) << FRAC_BITS);
    assign stat.at_limit = count_reg == limit_reg;

    always_comb
    begin
        unique case (cmd.sel)
            SEL_CROSS:
            begin
                word_a = zr_reg;
                word_b = zi_reg;
            end
            SEL_RR:
            begin
                word_a = zr_reg;
                word_b = zr_reg;
            end
            default:
            begin
                word_a = zi_reg;
                word_b = zi_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.phase)
            PH_LL:
            begin
                op_a = {1'b0, word_a[HALF_W-1:0]};
                op_b = {1'b0, word_b[HALF_W-1:0]};
            end
            PH_HL:
            begin
                op_a = {word_a[WORD_W-1], word_a[WORD_W-1:HALF_W]};
                op_b = {1'b0, word_b[HALF_W-1:0]};
            end
            PH_LH:
            begin
                op_a = {1'b0, word_a[HALF_W-1:0]};
                op_b = {word_b[WORD_W-1], word_b[WORD_W-1:HALF_W]};
            end
            default:
            begin
                op_a = {word_a[WORD_W-1], word_a[WORD_W-1:HALF_W]};
                op_b = {word_b[WORD_W-1], word_b[WORD_W-1:HALF_W]};
            end
        endcase
    end

    assign pp_next = op_a * op_b;
    assign pp_ext  = ACC_W'(pp_reg);

    always_comb
    begin
        unique case (pp_phase_reg)
            PH_LL:   pp_shl = pp_ext;
            PH_HL:   pp_shl = pp_ext <<< HALF_W;
            PH_LH:   pp_shl = pp_ext <<< HALF_W;
            default: pp_shl = pp_ext <<< (2 * HALF_W);
        endcase
    end

    assign acc_base = (pp_phase_reg == PH_LL) ? '0 : acc_reg;
    assign acc_next = acc_base + pp_shl;

    assign prod_shx = acc_reg >>> (FRAC_BITS - 1);
    assign prod_shs = acc_reg >>> FRAC_BITS;
    assign prod_sat = sat_word((cmd.sel == SEL_CROSS) ? prod_shx : prod_shs);

    assign zr_sum = ZS_W'(rr_reg) - ZS_W'(ii_reg) + ZS_W'(cr_reg);
    assign zi_sum = ZS_W'(cross_reg) + ZS_W'(ci_reg);

    assign pal_inc  = (PAL_W + 1)'(pal_acc_reg) + (PAL_W + 1)'(PAL_STEP);
    assign pal_step = (pal_inc >= (PAL_W + 1)'(PAL_MOD)) ?
                      PAL_W'(pal_inc - (PAL_W + 1)'(PAL_MOD)) : pal_inc[PAL_W-1:0];
    assign pal_out  = stat.at_limit ? '0 : pal_acc_reg + PAL_W'(PAL_BASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_cfg_reg <= LIMIT_RESET;
            pp_valid_reg  <= 1'b0;
            pp_phase_reg  <= PH_LL;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_cfg_reg <= cfg_data;
            end
            pp_valid_reg <= cmd.mul_en;
            pp_phase_reg <= cmd.phase;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            pp_reg <= pp_next;
        end
        if (pp_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load)
        begin
            cr_reg      <= in_data[WORD_W-1:0];
            ci_reg      <= in_data[IN_TDATA_W-1:WORD_W];
            zr_reg      <= '0;
            zi_reg      <= '0;
            rr_reg      <= '0;
            ii_reg      <= '0;
            count_reg   <= '0;
            pal_acc_reg <= '0;
            limit_reg   <= lim_eff[CNT_W-1:0];
        end
        if (cmd.wr_prod)
        begin
            unique case (cmd.sel)
                SEL_CROSS: cross_reg <= prod_sat;
                SEL_RR:    rr_reg    <= prod_sat;
                default:   ii_reg    <= prod_sat;
            endcase
        end
        if (cmd.upd)
        begin
            zr_reg      <= sat_word(ACC_W'(zr_sum));
            zi_reg      <= sat_word(ACC_W'(zi_sum));
            count_reg   <= count_reg + CNT_W'(1);
            pal_acc_reg <= pal_step;
        end
        if (cmd.out_load)
        begin
            out_pal_reg <= pal_out;
            out_cnt_reg <= cnt_ext[LIMIT_W-1:0];
        end
    end

    assign out_data = {(OUT_TDATA_W - LIMIT_W - PAL_W)'(0), out_cnt_reg, out_pal_reg};

endmodule
